>>> rtl/plj_pkg.sv
`default_nettype none

package plj_pkg;

  localparam int ANGLE_BITS_DEF = 16;

  localparam int ANG_W  = 16;
  localparam int LEN_W  = 16;
  localparam int TRIG_W = 16;
  localparam int OUT_W  = 19;
  localparam int NUM_ENTRIES = 6;

  localparam int IN_DATA_W  = 3 * ANG_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = ((NUM_ENTRIES * OUT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 2;

  // rotator datapath: x/y in q2.30 with headroom, residual angle in 2^-24 turn
  localparam int XY_W = 34;
  localparam int Z_W  = 25;
  localparam int PH_W = 24;
  localparam int CORDIC_ITERS    = 16;
  localparam int ITERS_PER_STAGE = 2;
  localparam int ROT_STAGES      = CORDIC_ITERS / ITERS_PER_STAGE;

  // phase register, rotation stages, rounding stage
  localparam int TRIG_STAGES = ROT_STAGES + 2;
  localparam int PROD_ST     = TRIG_STAGES;
  localparam int SUM_ST      = PROD_ST + 1;
  localparam int OUT_ST      = SUM_ST + 1;
  localparam int PIPE_STAGES = OUT_ST + 1;

  localparam int PROD_W = LEN_W + 1 + TRIG_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [XY_W-1:0]   CORDIC_ONE  = XY_W'(652032875);
  localparam logic signed [XY_W-1:0]   XY_HALF_LSB = XY_W'(16384);
  localparam logic signed [TRIG_W-1:0] TRIG_MAX    = TRIG_W'(32767);
  localparam logic signed [Z_W-1:0]    Z_EIGHTH    = Z_W'(2097152);
  localparam logic [PH_W-1:0]          PH_EIGHTH   = PH_W'(2097152);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THIGH = 2'd0,
    REG_CALF  = 2'd1,
    REG_FOOT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  typedef struct packed {
    logic torso;
    logic right;
  } flags_t;

  typedef logic [TRIG_STAGES-1:0] trig_en_t;

  // arctangent of 2^-i in units of 2^-24 turn
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = Z_W'(2097152);
      1:  r = Z_W'(1238021);
      2:  r = Z_W'(654136);
      3:  r = Z_W'(332050);
      4:  r = Z_W'(166669);
      5:  r = Z_W'(83416);
      6:  r = Z_W'(41718);
      7:  r = Z_W'(20860);
      8:  r = Z_W'(10430);
      9:  r = Z_W'(5215);
      10: r = Z_W'(2608);
      11: r = Z_W'(1304);
      12: r = Z_W'(652);
      13: r = Z_W'(326);
      14: r = Z_W'(163);
      default: r = Z_W'(81);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/plj_cordic.sv
`default_nettype none

module plj_cordic (
  input  wire logic                        clk,
  input  wire plj_pkg::trig_en_t           en,
  input  wire logic [plj_pkg::ANG_W-1:0]   angle,
  output plj_pkg::trig_t                   trig
);

  localparam int NR   = plj_pkg::ROT_STAGES;
  localparam int XY_W = plj_pkg::XY_W;
  localparam int Z_W  = plj_pkg::Z_W;
  localparam int PH_W = plj_pkg::PH_W;
  localparam int IPS  = plj_pkg::ITERS_PER_STAGE;

  logic [PH_W-1:0] phase_nxt;

  logic [1:0]             quad_r [NR+1];
  logic signed [XY_W-1:0] x_r    [NR+1];
  logic signed [XY_W-1:0] y_r    [NR+1];
  logic signed [Z_W-1:0]  z_r    [NR+1];

  plj_pkg::trig_t trig_nxt;
  plj_pkg::trig_t trig_r;

  // shift by half a quadrant so the top two bits give the nearest quadrant
  assign phase_nxt = {angle, 8'd0} + plj_pkg::PH_EIGHTH;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad_r[0] <= phase_nxt[PH_W-1:PH_W-2];
      z_r[0]    <= $signed({3'b000, phase_nxt[PH_W-3:0]}) - plj_pkg::Z_EIGHTH;
      x_r[0]    <= plj_pkg::CORDIC_ONE;
      y_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= NR; k++) begin : g_rot
    localparam int I0 = (k - 1) * IPS;
    logic signed [XY_W-1:0] xs [IPS+1];
    logic signed [XY_W-1:0] ys [IPS+1];
    logic signed [Z_W-1:0]  zs [IPS+1];

    always_comb begin
      xs[0] = x_r[k-1];
      ys[0] = y_r[k-1];
      zs[0] = z_r[k-1];
      for (int j = 0; j < IPS; j++) begin
        if (zs[j] >= 0) begin
          xs[j+1] = xs[j] - (ys[j] >>> (I0 + j));
          ys[j+1] = ys[j] + (xs[j] >>> (I0 + j));
          zs[j+1] = zs[j] - plj_pkg::atan_step(I0 + j);
        end else begin
          xs[j+1] = xs[j] + (ys[j] >>> (I0 + j));
          ys[j+1] = ys[j] - (xs[j] >>> (I0 + j));
          zs[j+1] = zs[j] + plj_pkg::atan_step(I0 + j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_r[k]    <= xs[IPS];
        y_r[k]    <= ys[IPS];
        z_r[k]    <= zs[IPS];
        quad_r[k] <= quad_r[k-1];
      end
    end
  end

  function automatic logic signed [plj_pkg::TRIG_W-1:0] sat_q15(
    input logic signed [XY_W-1:0] v
  );
    logic signed [XY_W-1:0] t;
    logic signed [plj_pkg::TRIG_W-1:0] r;
    t = (v + plj_pkg::XY_HALF_LSB) >>> 15;
    if (t > 32767) begin
      r = plj_pkg::TRIG_MAX;
    end else if (t < -32767) begin
      r = -plj_pkg::TRIG_MAX;
    end else begin
      r = t[plj_pkg::TRIG_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    logic signed [plj_pkg::TRIG_W-1:0] xq;
    logic signed [plj_pkg::TRIG_W-1:0] yq;
    xq = sat_q15(x_r[NR]);
    yq = sat_q15(y_r[NR]);
    case (quad_r[NR])
      2'd0: begin
        trig_nxt.cos_v = xq;
        trig_nxt.sin_v = yq;
      end
      2'd1: begin
        trig_nxt.cos_v = -yq;
        trig_nxt.sin_v = xq;
      end
      2'd2: begin
        trig_nxt.cos_v = -xq;
        trig_nxt.sin_v = -yq;
      end
      default: begin
        trig_nxt.cos_v = yq;
        trig_nxt.sin_v = -xq;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[plj_pkg::TRIG_STAGES-1]) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

`default_nettype wire

>>> rtl/planar_leg_jacobian_core.sv
`default_nettype none

// Position rows of the Jacobian of a planar hip/knee/ankle leg, torso frame to
// right foot. One item is accepted per cycle while in_tready is high. The three
// 16-step sine/cosine rotators run two rotation steps per register stage and
// are followed by a multiply stage, a sum stage and the output register. Each
// stage has its own valid bit and a stalled output only holds back stages that
// are full, so bubbles are squeezed out and in_tready stays high while any
// stage is empty. The user must write link lengths through the cfg port only
// while no item is in flight; the block does not enforce this. cfg_ready is
// always high. A reference other than the torso sets the tuser flag and zeroes
// all entries; a target other than the right foot zeroes all entries.
module planar_leg_jacobian_core #(
  parameter int ANGLE_BITS = plj_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // hip_angle, knee_angle, ankle_angle
  input  wire logic [plj_pkg::IN_DATA_W-1:0]     in_tdata,
  // ref_is_torso, target_is_right_foot
  input  wire logic [plj_pkg::IN_USER_W-1:0]     in_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  // jx_hip, jx_knee, jx_ankle, jy_hip, jy_knee, jy_ankle, zero pad
  output      logic [plj_pkg::OUT_DATA_W-1:0]    out_tdata,
  // bad_reference
  output      logic                              out_tuser,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [plj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [plj_pkg::LEN_W-1:0]         cfg_data
);

  localparam int NS     = plj_pkg::PIPE_STAGES;
  localparam int ANG_W  = plj_pkg::ANG_W;
  localparam int OUT_W  = plj_pkg::OUT_W;
  localparam int PROD_W = plj_pkg::PROD_W;
  localparam int ACC_W  = plj_pkg::ACC_W;
  localparam int DROP   = (ANGLE_BITS < ANG_W) ? (ANG_W - ANGLE_BITS) : 0;
  localparam logic [ANG_W-1:0] AMASK = ANG_W'({ANG_W{1'b1}} << DROP);
  localparam logic signed [ACC_W:0] ACC_HALF = (ACC_W + 1)'(16384);

  // configuration
  logic [plj_pkg::LEN_W-1:0] thigh_r, calf_r, foot_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thigh_r <= '0;
      calf_r  <= '0;
      foot_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        plj_pkg::REG_THIGH: thigh_r <= cfg_data;
        plj_pkg::REG_CALF:  calf_r  <= cfg_data;
        plj_pkg::REG_FOOT:  foot_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it or any later stage is empty
  logic [NS-1:0] v_r, v_nxt, en;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      en[i] = out_tready || (((~v_r) >> i) != '0);
    end
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < NS; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NS-1];

  plj_pkg::flags_t flags_r [plj_pkg::OUT_ST];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      flags_r[0] <= '{torso: in_tuser[0], right: in_tuser[1]};
    end
    for (int i = 1; i < plj_pkg::OUT_ST; i++) begin
      if (en[i]) begin
        flags_r[i] <= flags_r[i-1];
      end
    end
  end

  // cumulative joint angles, wrapped to one turn
  logic [ANG_W-1:0] ang_s1, ang_s12, ang_s123;

  always_comb begin
    logic [ANG_W-1:0] s12, s123;
    s12      = in_tdata[ANG_W-1:0] + in_tdata[2*ANG_W-1:ANG_W];
    s123     = s12 + in_tdata[3*ANG_W-1:2*ANG_W];
    ang_s1   = in_tdata[ANG_W-1:0] & AMASK;
    ang_s12  = s12 & AMASK;
    ang_s123 = s123 & AMASK;
  end

  plj_pkg::trig_t trig1, trig12, trig123;

  plj_cordic u_cordic_s1 (
    .clk   (clk),
    .en    (en[plj_pkg::TRIG_STAGES-1:0]),
    .angle (ang_s1),
    .trig  (trig1)
  );

  plj_cordic u_cordic_s12 (
    .clk   (clk),
    .en    (en[plj_pkg::TRIG_STAGES-1:0]),
    .angle (ang_s12),
    .trig  (trig12)
  );

  plj_cordic u_cordic_s123 (
    .clk   (clk),
    .en    (en[plj_pkg::TRIG_STAGES-1:0]),
    .angle (ang_s123),
    .trig  (trig123)
  );

  // length times trig products
  logic signed [PROD_W-1:0] p_tc_r, p_cc_r, p_fc_r, p_ts_r, p_cs_r, p_fs_r;

  always_ff @(posedge clk) begin
    if (en[plj_pkg::PROD_ST]) begin
      p_tc_r <= $signed({1'b0, thigh_r}) * trig1.cos_v;
      p_cc_r <= $signed({1'b0, calf_r})  * trig12.cos_v;
      p_fc_r <= $signed({1'b0, foot_r})  * trig123.cos_v;
      p_ts_r <= $signed({1'b0, thigh_r}) * trig1.sin_v;
      p_cs_r <= $signed({1'b0, calf_r})  * trig12.sin_v;
      p_fs_r <= $signed({1'b0, foot_r})  * trig123.sin_v;
    end
  end

  // column sums, outermost link first
  logic signed [ACC_W-1:0] xh_r, xk_r, xa_r, yh_r, yk_r, ya_r;
  logic signed [ACC_W-1:0] xk_nxt, yk_nxt;

  assign xk_nxt = ACC_W'(p_cc_r) + ACC_W'(p_fc_r);
  assign yk_nxt = ACC_W'(p_cs_r) + ACC_W'(p_fs_r);

  always_ff @(posedge clk) begin
    if (en[plj_pkg::SUM_ST]) begin
      xa_r <= ACC_W'(p_fc_r);
      xk_r <= xk_nxt;
      xh_r <= ACC_W'(p_tc_r) + xk_nxt;
      ya_r <= ACC_W'(p_fs_r);
      yk_r <= yk_nxt;
      yh_r <= ACC_W'(p_ts_r) + yk_nxt;
    end
  end

  function automatic logic [OUT_W-1:0] round_entry(
    input logic signed [ACC_W-1:0] acc,
    input logic                    neg
  );
    logic signed [ACC_W:0] a;
    logic signed [ACC_W:0] t;
    a = (ACC_W + 1)'(acc);
    t = neg ? (ACC_HALF - a) : (a + ACC_HALF);
    t = t >>> 15;
    return t[OUT_W-1:0];
  endfunction

  logic [OUT_W-1:0] jx_hip_r, jx_knee_r, jx_ankle_r, jy_hip_r, jy_knee_r, jy_ankle_r;
  logic             bad_r;

  always_ff @(posedge clk) begin
    if (en[plj_pkg::OUT_ST]) begin
      if (flags_r[plj_pkg::SUM_ST].torso && flags_r[plj_pkg::SUM_ST].right) begin
        jx_hip_r   <= round_entry(xh_r, 1'b1);
        jx_knee_r  <= round_entry(xk_r, 1'b1);
        jx_ankle_r <= round_entry(xa_r, 1'b1);
        jy_hip_r   <= round_entry(yh_r, 1'b0);
        jy_knee_r  <= round_entry(yk_r, 1'b0);
        jy_ankle_r <= round_entry(ya_r, 1'b0);
      end else begin
        jx_hip_r   <= '0;
        jx_knee_r  <= '0;
        jx_ankle_r <= '0;
        jy_hip_r   <= '0;
        jy_knee_r  <= '0;
        jy_ankle_r <= '0;
      end
      bad_r <= !flags_r[plj_pkg::SUM_ST].torso;
    end
  end

  assign out_tdata = plj_pkg::OUT_DATA_W'({jy_ankle_r, jy_knee_r, jy_hip_r,
                                           jx_ankle_r, jx_knee_r, jx_hip_r});
  assign out_tuser = bad_r;

`ifndef SYNTHESIS
  // a bad reference always comes out with a zero matrix
  a_bad_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("bad reference item with nonzero entries");

  // input is held off only when every stage holds an item
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v_r == '1)
    else $error("input stalled while a stage is empty");

  // items in flight change only by accepts and deliveries
  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      $countones(v_r) == $past($countones(v_r))
                         + ($past(in_tvalid && in_tready) ? 1 : 0)
                         - ($past(out_tvalid && out_tready) ? 1 : 0))
    else $error("item lost or duplicated in pipeline");
`endif

endmodule

`default_nettype wire
